/* rtl/i2cm_pkg.sv */
package i2cm_pkg;

	localparam logic [15:0] HALF_PERIOD_RESET = 16'd150;
	localparam logic [15:0] ACK_TIMEOUT_RESET = 16'd2000;
	localparam int          QUEUE_DEPTH       = 2;
	localparam logic [3:0]  BITS_PER_BYTE     = 4'd8;

	localparam logic CFG_HALF_PERIOD = 1'b0;
	localparam logic CFG_ACK_TIMEOUT = 1'b1;

	localparam logic [2:0] REQ_START = 3'd0;
	localparam logic [2:0] REQ_STOP  = 3'd1;
	localparam logic [2:0] REQ_WRITE = 3'd2;
	localparam logic [2:0] REQ_READ  = 3'd3;
	localparam logic [2:0] REQ_CHECK = 3'd4;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_START,
		CMD_STOP,
		CMD_WRITE,
		CMD_READ,
		CMD_CHECK
	} cmd_t;

	typedef enum logic [4:0] {
		PH_IDLE   = 5'd0,
		PH_START1 = 5'd1,
		PH_START2 = 5'd2,
		PH_STOP1  = 5'd3,
		PH_STOP2  = 5'd4,
		PH_WR_HI  = 5'd5,
		PH_WR_LO  = 5'd6,
		PH_RD_LO  = 5'd7,
		PH_RD_HI  = 5'd8,
		PH_AK1    = 5'd9,
		PH_AK2    = 5'd10,
		PH_WA1    = 5'd11,
		PH_WA2    = 5'd12,
		PH_POLL   = 5'd13
	} phase_t;

	typedef struct packed {
		logic       cmd_valid;
		logic [2:0] req_type;
		logic [7:0] tx_byte;
		logic       send_ack;
		logic       sda_in;
	} in_item_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_failed;
	} out_item_t;

	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] tx_byte;
		logic       send_ack;
		logic       sda_in;
	} tick_t;

endpackage

/* rtl/i2cm_front.sv */
module i2cm_front #(
	parameter int QDEPTH = i2cm_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  i2cm_pkg::in_item_t in_data,
	output logic              q_valid,
	input  logic              q_take,
	output i2cm_pkg::tick_t    q_data
);
	import i2cm_pkg::*;

	localparam int PW = $clog2(QDEPTH);
	localparam int CW = $clog2(QDEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(QDEPTH - 1);
	localparam logic [CW-1:0] FULL = CW'(QDEPTH);

	tick_t         slot_q [QDEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	tick_t         tick;
	logic          push;
	logic          pop;

	// classify: anything but a known request becomes a plain tick
	always_comb begin
		tick.tx_byte  = in_data.tx_byte;
		tick.send_ack = in_data.send_ack;
		tick.sda_in   = in_data.sda_in;
		tick.cmd      = CMD_NONE;
		if (in_data.cmd_valid) begin
			case (in_data.req_type)
				REQ_START: tick.cmd = CMD_START;
				REQ_STOP:  tick.cmd = CMD_STOP;
				REQ_WRITE: tick.cmd = CMD_WRITE;
				REQ_READ:  tick.cmd = CMD_READ;
				REQ_CHECK: tick.cmd = CMD_CHECK;
				default:   tick.cmd = CMD_NONE;
			endcase
		end
	end

	assign in_ready = (count_q != FULL);
	assign q_valid  = (count_q != '0);
	assign q_data   = slot_q[rd_ptr_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_take && q_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= tick;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/i2cm_seq.sv */
module i2cm_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	output logic               q_take,
	input  i2cm_pkg::tick_t     q_data,
	output logic               out_valid,
	input  logic               out_ready,
	output i2cm_pkg::out_item_t out_data,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data
);
	import i2cm_pkg::*;

	phase_t      phase_q, phase_n;
	logic [3:0]  bit_q, bit_n;
	logic [15:0] delay_q, delay_n;
	logic [15:0] poll_q, poll_n;
	logic [7:0]  shift_q, shift_n;
	logic        scl_q, scl_n;
	logic        sda_q, sda_n;
	logic        drive_q, drive_n;
	logic        fail_q, fail_n;
	logic        ackc_q, ackc_n;
	logic [7:0]  rx_q, rx_n;
	logic        done_n;
	logic [15:0] hp_q;
	logic [15:0] to_q;
	logic [15:0] hp_eff;
	logic [15:0] d_inc;
	logic [3:0]  b_inc;
	logic        out_valid_q;
	out_item_t   out_data_q;

	assign q_take    = q_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign hp_eff    = (hp_q == '0) ? 16'd1 : hp_q;
	assign d_inc     = delay_q + 16'd1;
	assign b_inc     = bit_q + 4'd1;

	always_comb begin
		phase_n = phase_q;
		bit_n   = bit_q;
		delay_n = delay_q;
		poll_n  = poll_q;
		shift_n = shift_q;
		scl_n   = scl_q;
		sda_n   = sda_q;
		drive_n = drive_q;
		fail_n  = fail_q;
		ackc_n  = ackc_q;
		rx_n    = rx_q;
		done_n  = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				case (q_data.cmd)
					CMD_START: begin
						drive_n = 1'b1; sda_n = 1'b1; scl_n = 1'b1;
						phase_n = PH_START1; delay_n = '0;
					end
					CMD_STOP: begin
						drive_n = 1'b1; sda_n = 1'b0; scl_n = 1'b1;
						phase_n = PH_STOP1; delay_n = '0;
					end
					CMD_WRITE: begin
						drive_n = 1'b1;
						sda_n   = q_data.tx_byte[7];
						shift_n = {q_data.tx_byte[6:0], 1'b0};
						scl_n   = 1'b1;
						bit_n   = '0;
						phase_n = PH_WR_HI; delay_n = '0;
					end
					CMD_READ: begin
						drive_n = 1'b0; scl_n = 1'b0;
						shift_n = '0; bit_n = '0;
						ackc_n  = q_data.send_ack;
						phase_n = PH_RD_LO; delay_n = '0;
					end
					CMD_CHECK: begin
						fail_n  = 1'b0; drive_n = 1'b0; sda_n = 1'b1;
						phase_n = PH_WA1; delay_n = '0;
					end
					default: ;
				endcase
			end
			PH_POLL: begin
				if (!q_data.sda_in) begin
					scl_n = 1'b0; phase_n = PH_IDLE; done_n = 1'b1;
				end else if (poll_q >= to_q) begin
					// give up: flag and run a full stop
					fail_n  = 1'b1;
					drive_n = 1'b1; sda_n = 1'b0; scl_n = 1'b1;
					phase_n = PH_STOP1; delay_n = '0;
				end else begin
					poll_n = poll_q + 16'd1;
				end
			end
			default: begin
				delay_n = d_inc;
				if (d_inc >= hp_eff) begin
					case (phase_q)
						PH_START1: begin sda_n = 1'b0; phase_n = PH_START2; delay_n = '0; end
						PH_STOP1:  begin sda_n = 1'b1; phase_n = PH_STOP2;  delay_n = '0; end
						PH_START2, PH_STOP2, PH_AK2: begin
							scl_n = 1'b0; phase_n = PH_IDLE; done_n = 1'b1;
						end
						PH_WR_HI: begin scl_n = 1'b0; phase_n = PH_WR_LO; delay_n = '0; end
						PH_WR_LO: begin
							bit_n = b_inc;
							if (b_inc >= BITS_PER_BYTE) begin
								phase_n = PH_IDLE; done_n = 1'b1;
							end else begin
								sda_n   = shift_q[7];
								shift_n = {shift_q[6:0], 1'b0};
								scl_n   = 1'b1;
								phase_n = PH_WR_HI; delay_n = '0;
							end
						end
						PH_RD_LO: begin
							scl_n   = 1'b1;
							shift_n = {shift_q[6:0], q_data.sda_in};
							phase_n = PH_RD_HI; delay_n = '0;
						end
						PH_RD_HI: begin
							bit_n = b_inc;
							scl_n = 1'b0;
							delay_n = '0;
							if (b_inc >= BITS_PER_BYTE) begin
								drive_n = 1'b1;
								sda_n   = !ackc_q;
								rx_n    = shift_q;
								phase_n = PH_AK1;
							end else begin
								phase_n = PH_RD_LO;
							end
						end
						PH_AK1:  begin scl_n = 1'b1; phase_n = PH_AK2; delay_n = '0; end
						PH_WA1:  begin scl_n = 1'b1; phase_n = PH_WA2; delay_n = '0; end
						PH_WA2:  begin phase_n = PH_POLL; poll_n = '0; end
						default: phase_n = PH_IDLE;
					endcase
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bit_q   <= '0;
			delay_q <= '0;
			poll_q  <= '0;
			shift_q <= '0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			drive_q <= 1'b1;
			fail_q  <= 1'b0;
			ackc_q  <= 1'b0;
			rx_q    <= '0;
		end else if (q_take) begin
			phase_q <= phase_n;
			bit_q   <= bit_n;
			delay_q <= delay_n;
			poll_q  <= poll_n;
			shift_q <= shift_n;
			scl_q   <= scl_n;
			sda_q   <= sda_n;
			drive_q <= drive_n;
			fail_q  <= fail_n;
			ackc_q  <= ackc_n;
			rx_q    <= rx_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hp_q <= HALF_PERIOD_RESET;
			to_q <= ACK_TIMEOUT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_HALF_PERIOD: hp_q <= cfg_data;
				CFG_ACK_TIMEOUT: to_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_take) begin
			out_data_q.scl_level  <= scl_n;
			out_data_q.sda_level  <= sda_n;
			out_data_q.sda_drive  <= drive_n;
			out_data_q.busy_res   <= (phase_n != PH_IDLE);
			out_data_q.done_res   <= done_n;
			out_data_q.rx_byte    <= rx_n;
			out_data_q.ack_failed <= fail_n;
		end
	end

`ifndef SYNTHESIS
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q.done_res |-> !out_data_q.busy_res)
		else $error("done reported while still busy");
	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_q <= BITS_PER_BYTE)
		else $error("bit counter past a full byte");
	a_poll_released: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_POLL |-> !drive_q)
		else $error("SDA driven while polling for acknowledge");
	a_read_released: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_RD_LO || phase_q == PH_RD_HI |-> !drive_q)
		else $error("SDA driven while reading data bits");
`endif

endmodule

/* rtl/i2c_master_bit_sequencer.sv */
// I2C master bit sequencer, advanced by one tick per request.
// in_valid/in_ready/in_data: one request per bus tick, carrying an optional
//   command (start, stop, write, read with ACK/NACK, check acknowledge) and
//   the sampled SDA level. Commands offered while busy are ignored.
// out_valid/out_ready/out_data: exactly one result per request, in order:
//   SCL level, SDA level and drive enable, busy, done pulse, last received
//   byte and the acknowledge-failure flag.
// cfg_we/cfg_index/cfg_data: index 0 half-period ticks, index 1 acknowledge
//   timeout polls; write only while idle.
// Path: each request passes through a queue slot, then the output register.
// Throughput: one request per cycle while out_ready holds; the sequencer
//   advances one step per request taken from the two-entry queue.
// Reset: lines SCL high, SDA high and driven, phase idle, half period 150,
//   timeout 2000, queue and output register empty.
// Stall: a waiting result holds in the output register, the queue takes up
//   to two more requests, then in_ready drops until out_ready returns.
module i2c_master_bit_sequencer #(
	parameter int QDEPTH = i2cm_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  i2cm_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output i2cm_pkg::out_item_t out_data,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data
);
	import i2cm_pkg::*;

	logic  q_valid;
	logic  q_take;
	tick_t q_data;

	i2cm_front #(
		.QDEPTH(QDEPTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data (in_data),
		.q_valid (q_valid),
		.q_take  (q_take),
		.q_data  (q_data)
	);

	i2cm_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_take   (q_take),
		.q_data   (q_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;
	import i2cm_pkg::*;

	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int REPORT_MAX  = 10;

	// request codes the block must ignore
	localparam logic [2:0] REQ_SPARE_A = 3'd5;
	localparam logic [2:0] REQ_SPARE_C = 3'd7;

	// how the sampled SDA level is chosen while a command runs
	localparam int SDA_RANDOM = 0;
	localparam int SDA_HIGH   = 1;
	localparam int SDA_LOW    = 2;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_ready;
	out_item_t   out_data;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_data;

	i2c_master_bit_sequencer uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// shadow of the sequencer
	phase_t      ph;
	logic [3:0]  nbits;
	logic [15:0] dly;
	logic [15:0] polls;
	logic [7:0]  shreg;
	logic        scl, sda_o, drv;
	logic        fail_flag, ack_sel;
	logic [7:0]  rx_last;
	logic [15:0] cfg_half;
	logic [15:0] cfg_timeout;

	out_item_t bus_expect[$];
	int        mismatches = 0;
	int        strays = 0;
	int        reported = 0;
	int        cycles = 0;
	bit        src_gaps = 1'b1;
	bit        sink_gaps = 1'b1;
	int        long_hold = 0;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic void shadow_reset();
		ph = PH_IDLE;
		nbits = '0;
		dly = '0;
		polls = '0;
		shreg = '0;
		scl = 1'b1;
		sda_o = 1'b1;
		drv = 1'b1;
		fail_flag = 1'b0;
		ack_sel = 1'b0;
		rx_last = '0;
		cfg_half = HALF_PERIOD_RESET;
		cfg_timeout = ACK_TIMEOUT_RESET;
	endfunction

	function automatic void arm(input phase_t nxt);
		ph = nxt;
		dly = '0;
	endfunction

	function automatic void begin_stop();
		drv = 1'b1;
		sda_o = 1'b0;
		scl = 1'b1;
		arm(PH_STOP1);
	endfunction

	// advance the shadow by one bus tick and return the lines as they then stand
	function automatic out_item_t step_bus(input in_item_t t);
		out_item_t   r;
		logic        done;
		logic [15:0] hp;
		done = 1'b0;
		hp = (cfg_half == '0) ? 16'd1 : cfg_half;
		if (ph == PH_IDLE) begin
			if (t.cmd_valid) begin
				case (t.req_type)
					REQ_START: begin
						drv = 1'b1;
						sda_o = 1'b1;
						scl = 1'b1;
						arm(PH_START1);
					end
					REQ_STOP: begin_stop();
					REQ_WRITE: begin
						drv = 1'b1;
						sda_o = t.tx_byte[7];
						shreg = {t.tx_byte[6:0], 1'b0};
						scl = 1'b1;
						nbits = '0;
						arm(PH_WR_HI);
					end
					REQ_READ: begin
						drv = 1'b0;
						scl = 1'b0;
						shreg = '0;
						nbits = '0;
						ack_sel = t.send_ack;
						arm(PH_RD_LO);
					end
					REQ_CHECK: begin
						fail_flag = 1'b0;
						drv = 1'b0;
						sda_o = 1'b1;
						arm(PH_WA1);
					end
					default: ;
				endcase
			end
		end else if (ph == PH_POLL) begin
			if (!t.sda_in) begin
				scl = 1'b0;
				ph = PH_IDLE;
				done = 1'b1;
			end else if (polls >= cfg_timeout) begin
				fail_flag = 1'b1;
				begin_stop();
			end else begin
				polls = polls + 16'd1;
			end
		end else begin
			dly = dly + 16'd1;
			if (dly >= hp) begin
				case (ph)
					PH_START1: begin
						sda_o = 1'b0;
						arm(PH_START2);
					end
					PH_STOP1: begin
						sda_o = 1'b1;
						arm(PH_STOP2);
					end
					PH_START2, PH_STOP2, PH_AK2: begin
						scl = 1'b0;
						ph = PH_IDLE;
						done = 1'b1;
					end
					PH_WR_HI: begin
						scl = 1'b0;
						arm(PH_WR_LO);
					end
					PH_WR_LO: begin
						nbits = nbits + 4'd1;
						if (nbits >= BITS_PER_BYTE) begin
							ph = PH_IDLE;
							done = 1'b1;
						end else begin
							sda_o = shreg[7];
							shreg = {shreg[6:0], 1'b0};
							scl = 1'b1;
							arm(PH_WR_HI);
						end
					end
					PH_RD_LO: begin
						scl = 1'b1;
						shreg = {shreg[6:0], t.sda_in};
						arm(PH_RD_HI);
					end
					PH_RD_HI: begin
						nbits = nbits + 4'd1;
						scl = 1'b0;
						if (nbits >= BITS_PER_BYTE) begin
							drv = 1'b1;
							sda_o = !ack_sel;
							rx_last = shreg;
							arm(PH_AK1);
						end else begin
							arm(PH_RD_LO);
						end
					end
					PH_AK1: begin
						scl = 1'b1;
						arm(PH_AK2);
					end
					PH_WA1: begin
						scl = 1'b1;
						arm(PH_WA2);
					end
					PH_WA2: begin
						ph = PH_POLL;
						polls = '0;
					end
					default: ph = PH_IDLE;
				endcase
			end
		end
		r.scl_level = scl;
		r.sda_level = sda_o;
		r.sda_drive = drv;
		r.busy_res = (ph != PH_IDLE);
		r.done_res = done;
		r.rx_byte = rx_last;
		r.ack_failed = fail_flag;
		return r;
	endfunction

	function automatic logic pick_sda(input int mode);
		case (mode)
			SDA_HIGH: return 1'b1;
			SDA_LOW: return 1'b0;
			// mostly high while polling, so that timeouts do happen
			default: return (ph == PH_POLL) ? ($urandom_range(0, 3) != 0)
			                                : 1'($urandom_range(0, 1));
		endcase
	endfunction

	// a tick with random content; any command in it is ignored while busy
	function automatic in_item_t busy_tick(input int mode);
		in_item_t t;
		t.cmd_valid = ($urandom_range(0, 3) == 0);
		t.req_type = 3'($urandom_range(0, 7));
		t.tx_byte = 8'($urandom_range(0, 255));
		t.send_ack = 1'($urandom_range(0, 1));
		t.sda_in = pick_sda(mode);
		return t;
	endfunction

	task automatic send_tick(input in_item_t t);
		if (src_gaps && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= t;
		do @(posedge clk); while (!in_ready);
		bus_expect.push_back(step_bus(t));
	endtask

	task automatic run_to_idle(input int mode);
		while (ph != PH_IDLE)
			send_tick(busy_tick(mode));
	endtask

	task automatic issue(input logic [2:0] req, input logic [7:0] tx, input logic ack,
			input int mode);
		in_item_t t;
		t = busy_tick(mode);
		t.cmd_valid = 1'b1;
		t.req_type = req;
		t.tx_byte = tx;
		t.send_ack = ack;
		send_tick(t);
		run_to_idle(mode);
	endtask

	// finish the running command and wait until every result is back
	task automatic quiesce();
		run_to_idle(SDA_RANDOM);
		in_valid <= 1'b0;
		while (bus_expect.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(input logic [15:0] hp, input logic [15:0] polls_max);
		quiesce();
		cfg_we <= 1'b1;
		cfg_index <= CFG_HALF_PERIOD;
		cfg_data <= hp;
		@(posedge clk);
		cfg_index <= CFG_ACK_TIMEOUT;
		cfg_data <= polls_max;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_half = hp;
		cfg_timeout = polls_max;
	endtask

	task automatic random_traffic(input int n);
		in_item_t t;
		int       pick;
		for (int i = 0; i < n; i++) begin
			t = busy_tick(SDA_RANDOM);
			if (ph == PH_IDLE) begin
				pick = $urandom_range(0, 19);
				t.cmd_valid = (pick < 18);
				t.req_type = (pick < 16) ? 3'($urandom_range(REQ_START, REQ_CHECK))
				                         : 3'($urandom_range(REQ_SPARE_A, REQ_SPARE_C));
			end
			send_tick(t);
		end
	endtask

	task automatic test_reset_levels();
		in_item_t t;
		for (int i = 0; i < 3; i++) begin
			t = busy_tick(SDA_RANDOM);
			t.cmd_valid = 1'b0;
			send_tick(t);
		end
	endtask

	task automatic test_directed_commands();
		configure(16'd1, 16'd2);
		issue(REQ_START, 8'h00, 1'b0, SDA_RANDOM);
		issue(REQ_WRITE, 8'h00, 1'b0, SDA_RANDOM);
		issue(REQ_WRITE, 8'hFF, 1'b1, SDA_RANDOM);
		issue(REQ_WRITE, 8'hA5, 1'b0, SDA_RANDOM);
		issue(REQ_READ, 8'h5A, 1'b1, SDA_RANDOM);
		issue(REQ_READ, 8'h00, 1'b0, SDA_HIGH);
		issue(REQ_READ, 8'hFF, 1'b1, SDA_LOW);
		issue(REQ_CHECK, 8'h00, 1'b0, SDA_LOW);
		// time out, then clear the flag with a good acknowledge
		issue(REQ_CHECK, 8'h00, 1'b0, SDA_HIGH);
		issue(REQ_CHECK, 8'h00, 1'b0, SDA_LOW);
		issue(REQ_STOP, 8'h00, 1'b0, SDA_RANDOM);
		for (int r = REQ_SPARE_A; r <= REQ_SPARE_C; r++)
			issue(r[2:0], 8'hC3, 1'b1, SDA_RANDOM);
	endtask

	task automatic test_zero_settings();
		configure(16'd0, 16'd0);
		issue(REQ_WRITE, 8'h3C, 1'b0, SDA_RANDOM);
		issue(REQ_CHECK, 8'h00, 1'b0, SDA_HIGH);
		issue(REQ_READ, 8'h00, 1'b0, SDA_RANDOM);
		issue(REQ_START, 8'h00, 1'b1, SDA_RANDOM);
	endtask

	task automatic test_slow_bus();
		src_gaps = 1'b0;
		sink_gaps = 1'b0;
		configure(16'd24, 16'hFFFF);
		issue(REQ_START, 8'h00, 1'b0, SDA_RANDOM);
		src_gaps = 1'b1;
		sink_gaps = 1'b1;
	endtask

	task automatic test_long_timeout();
		src_gaps = 1'b0;
		sink_gaps = 1'b0;
		configure(16'd1, 16'd40);
		issue(REQ_CHECK, 8'h00, 1'b0, SDA_HIGH);
		src_gaps = 1'b1;
		sink_gaps = 1'b1;
	endtask

	task automatic test_backpressure();
		configure(16'd2, 16'd3);
		long_hold = 300;
		random_traffic(100);
	endtask

	task automatic test_random_traffic();
		configure(16'd1, 16'd0);
		random_traffic(100);
		configure(16'd3, 16'd5);
		random_traffic(100);
		configure(16'd0, 16'd1);
		random_traffic(60);
		// no idling on either side for the last stretch
		src_gaps = 1'b0;
		sink_gaps = 1'b0;
		configure(16'd1, 16'd3);
		random_traffic(70);
	endtask

	initial begin
		shadow_reset();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_HALF_PERIOD;
		cfg_data = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_levels();
		test_directed_commands();
		test_zero_settings();
		test_slow_bus();
		test_long_timeout();
		test_backpressure();
		test_random_traffic();
		quiesce();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && strays == 0 && bus_expect.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin
		int n;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (long_hold > 0) begin
				n = long_hold;
				long_hold = 0;
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
				out_ready <= 1'b1;
			end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	function automatic void check_result(input out_item_t want, input out_item_t got);
		bit bad;
		bad = got.scl_level !== want.scl_level || got.sda_level !== want.sda_level
			|| got.sda_drive !== want.sda_drive || got.busy_res !== want.busy_res
			|| got.done_res !== want.done_res || got.rx_byte !== want.rx_byte
			|| got.ack_failed !== want.ack_failed;
		if (bad) begin
			mismatches++;
			if (reported < REPORT_MAX) begin
				reported++;
				$display("mismatch at cycle %0d (expected/actual): scl %b/%b sda %b/%b",
					cycles, want.scl_level, got.scl_level, want.sda_level, got.sda_level);
				$display("  drive %b/%b busy %b/%b done %b/%b rx %h/%h fail %b/%b",
					want.sda_drive, got.sda_drive, want.busy_res, got.busy_res,
					want.done_res, got.done_res, want.rx_byte, got.rx_byte,
					want.ack_failed, got.ack_failed);
			end
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (bus_expect.size() == 0) begin
				strays++;
				if (reported < REPORT_MAX) begin
					reported++;
					$display("unexpected result at cycle %0d: %h", cycles, out_data);
				end
			end else begin
				check_result(bus_expect.pop_front(), out_data);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

endmodule
